FILE: hdl/ajb_pkg.sv
// Package for the audio jitter buffer: opcodes, modes, sizes and the request type
// passed from the front part to the back part. No dependencies.
package ajb_pkg;

    localparam int RingDepth = 256;
    localparam int PtrW = $clog2(RingDepth) + 1;
    localparam int AddrW = $clog2(RingDepth);
    localparam int MaxRepeat = 8;
    localparam int RepW = $clog2(MaxRepeat + 1);
    localparam int QDepth = 4;
    localparam int QAddrW = $clog2(QDepth);

    typedef enum logic [1:0] {
        OP_HEADER = 2'd0,
        OP_FRAME  = 2'd1,
        OP_BATCH  = 2'd2,
        OP_READ   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_BUFFERING = 2'd1,
        MODE_STREAMING = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CFG_RATIO  = 2'd0,
        CFG_PREBUF = 2'd1,
        CFG_TARGET = 2'd2,
        CFG_MAX    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_SILENCE = 2'd1,
        ST_READ    = 2'd2,
        ST_EMIT    = 2'd3
    } t_state;

    typedef struct packed {
        t_opcode     op;
        logic        gap_ok;
        logic [7:0]  gap;
        logic [15:0] count;
        logic [15:0] left;
        logic [15:0] right;
        logic        eop;
        logic [31:0] now;
    } t_req;

endpackage

FILE: hdl/ajb_front.sv
// Front part of the audio jitter buffer: accepts items, tracks the sequence number
// and queues classified requests for the back part. Uses ajb_pkg.
module ajb_front
    import ajb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_seq_num,
    input  logic [15:0] i_frame_count,
    input  logic [15:0] i_left_in,
    input  logic [15:0] i_right_in,
    input  logic        i_end_of_packet,
    input  logic [31:0] i_time_us,
    output logic        o_req_valid,
    output t_req        o_req,
    input  logic        i_req_pop
);

    t_req               r_queue [QDepth];
    logic [QAddrW:0]    r_wr, r_rd;
    logic [7:0]         r_next_seq;
    logic               r_started;
    logic               acc;
    logic [7:0]         gap;
    t_req               req;

    assign o_stall = ((r_wr - r_rd) == (QAddrW+1)'(QDepth));
    assign acc = i_valid && !o_stall;
    assign gap = i_seq_num - r_next_seq;
    assign o_req_valid = (r_wr != r_rd);
    assign o_req = r_queue[r_rd[QAddrW-1:0]];

    always_comb begin
        req.op = t_opcode'(i_opcode);
        req.gap_ok = r_started && gap != 8'd0 && !gap[7];
        req.gap = gap;
        req.count = i_frame_count;
        req.left = i_left_in;
        req.right = i_right_in;
        req.eop = i_end_of_packet;
        req.now = i_time_us;
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_queue[r_wr[QAddrW-1:0]] <= req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_next_seq <= '0;
            r_started <= 1'b0;
        end else begin
            if (acc) begin
                r_wr <= r_wr + 1'b1;
                if (t_opcode'(i_opcode) == OP_HEADER) begin
                    r_started <= 1'b1;
                    r_next_seq <= i_seq_num + 8'd1;
                end
            end
            if (i_req_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

endmodule

FILE: hdl/ajb_back.sv
// Back part of the audio jitter buffer: frame ring, mode, counters and the output
// register. Uses ajb_pkg and takes requests from ajb_front.
module ajb_back
    import ajb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  t_req        i_req,
    output logic        o_req_pop,
    input  logic [3:0]  i_ratio,
    input  logic [8:0]  i_prebuf,
    input  logic [8:0]  i_target,
    input  logic [8:0]  i_max,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_left_out,
    output logic [15:0] o_right_out,
    output logic        o_last_copy,
    output logic        o_underrun_flag,
    output logic [1:0]  o_stream_mode,
    output logic [8:0]  o_fill_level,
    output logic [31:0] o_delay_us,
    output logic        o_delay_valid,
    output logic [31:0] o_packets_seen,
    output logic [31:0] o_packets_missing,
    output logic [31:0] o_overrun_count,
    output logic [31:0] o_underrun_count
);

    logic [63:0]      r_mem [RingDepth];
    logic [63:0]      r_rdata;
    logic [PtrW-1:0]  r_wp, r_rp;
    t_mode            r_mode;
    t_state           r_state, n_state;
    logic [31:0]      r_arrival, r_seen, r_lost, r_over, r_under;
    logic [8:0]       r_sil;
    logic [23:0]      r_prod;
    logic             r_eop;
    logic [31:0]      r_now;
    logic             r_popped, r_uflag;
    logic [RepW-1:0]  r_k, r_ratio;
    logic             r_ovalid;
    logic [PtrW-1:0]  fill;
    logic             full;
    logic [RepW-1:0]  ratio_eff;
    logic             emit_ok;
    logic [PtrW-1:0]  mode_fill;
    logic             mem_we;
    logic [63:0]      mem_wd;
    logic             take;
    logic [9:0]       prebuf_w;
    logic [9:0]       cap_lim;
    logic [23:0]      cap;

    assign fill = r_wp - r_rp;
    assign full = fill >= PtrW'(RingDepth);
    assign emit_ok = !r_ovalid || !i_stall;
    assign prebuf_w = {1'b0, i_prebuf};
    assign cap_lim = (prebuf_w > 10'(RingDepth)) ? 10'(RingDepth) : prebuf_w;
    assign cap = (r_prod > 24'(cap_lim)) ? 24'(cap_lim) : r_prod;

    always_comb begin
        if (i_ratio == 4'd0) ratio_eff = RepW'(1);
        else if (i_ratio > 4'(MaxRepeat)) ratio_eff = RepW'(MaxRepeat);
        else ratio_eff = RepW'(i_ratio);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    if (i_req.op == OP_HEADER && i_req.gap_ok) n_state = ST_SILENCE;
                    else if (i_req.op == OP_READ) n_state = ST_READ;
                end
            end
            ST_SILENCE: begin
                if (r_sil == 9'd0 || full) n_state = ST_IDLE;
            end
            ST_READ: n_state = ST_EMIT;
            ST_EMIT: begin
                if (emit_ok && r_k + 1'b1 == r_ratio) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        take = (r_state == ST_IDLE) && i_req_valid;
        o_req_pop = take;
        mem_we = 1'b0;
        mem_wd = 64'd0;
        if (take && i_req.op == OP_FRAME && !full) begin
            mem_we = 1'b1;
            mem_wd = {i_req.left, i_req.right, r_arrival};
        end else if (r_state == ST_SILENCE && r_sil != 9'd0 && r_sil != 9'h1ff && !full) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp[AddrW-1:0]] <= mem_wd;
        end
        if (r_state == ST_READ) begin
            r_rdata <= r_mem[r_rp[AddrW-1:0]];
        end
    end

    always_comb begin
        mode_fill = fill + PtrW'(mem_we);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wp <= '0;
            r_rp <= '0;
            r_mode <= MODE_IDLE;
            r_arrival <= '0;
            r_seen <= '0;
            r_lost <= '0;
            r_over <= '0;
            r_under <= '0;
            r_ovalid <= 1'b0;
            r_k <= '0;
            r_sil <= '0;
        end else begin
            r_state <= n_state;
            if (mem_we) r_wp <= r_wp + 1'b1;
            if (r_state == ST_EMIT && emit_ok) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (take) begin
                r_eop <= i_req.eop;
                r_now <= i_req.now;
                r_prod <= 24'(i_req.gap) * 24'(i_req.count);
                case (i_req.op)
                    OP_HEADER: begin
                        r_seen <= r_seen + 32'd1;
                        r_arrival <= i_req.now;
                        if (i_req.gap_ok) begin
                            r_lost <= r_lost + 32'(i_req.gap);
                            r_sil <= 9'h1ff;
                        end else if (i_req.eop) begin
                            if (r_mode == MODE_IDLE || r_mode == MODE_BUFFERING) begin
                                r_mode <= (fill >= PtrW'(i_prebuf)) ?
                                    MODE_STREAMING : MODE_BUFFERING;
                            end
                        end
                    end
                    OP_FRAME: begin
                        if (full) r_over <= r_over + 32'd1;
                        if (i_req.eop &&
                            (r_mode == MODE_IDLE || r_mode == MODE_BUFFERING)) begin
                            r_mode <= (mode_fill >= PtrW'(i_prebuf)) ?
                                MODE_STREAMING : MODE_BUFFERING;
                        end
                    end
                    OP_BATCH: begin
                        if (r_mode == MODE_STREAMING && fill > PtrW'(i_max) &&
                            fill > PtrW'(i_target)) begin
                            r_rp <= r_rp + (fill - PtrW'(i_target));
                            r_over <= r_over + 32'(fill - PtrW'(i_target));
                        end
                    end
                    OP_READ: begin
                        r_ratio <= ratio_eff;
                        r_k <= '0;
                        r_popped <= 1'b0;
                        r_uflag <= 1'b0;
                        if (r_mode == MODE_STREAMING) begin
                            if (fill == '0) begin
                                r_uflag <= 1'b1;
                                r_under <= r_under + 32'd1;
                            end else begin
                                r_popped <= 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (r_state == ST_SILENCE) begin
                if (r_sil == 9'h1ff) begin
                    r_sil <= cap[8:0];
                end else if (r_sil != 9'd0 && !full) begin
                    r_sil <= r_sil - 9'd1;
                end
                if (n_state == ST_IDLE && r_eop &&
                    (r_mode == MODE_IDLE || r_mode == MODE_BUFFERING)) begin
                    r_mode <= (fill >= PtrW'(i_prebuf)) ? MODE_STREAMING : MODE_BUFFERING;
                end
            end
            if (r_state == ST_READ && r_popped) begin
                r_rp <= r_rp + 1'b1;
            end
            if (r_state == ST_EMIT && emit_ok) begin
                r_k <= r_k + 1'b1;
                o_left_out <= r_popped ? r_rdata[63:48] : 16'd0;
                o_right_out <= r_popped ? r_rdata[47:32] : 16'd0;
                o_last_copy <= (r_k + 1'b1 == r_ratio);
                o_underrun_flag <= r_uflag;
                o_stream_mode <= r_mode;
                o_fill_level <= fill[8:0];
                o_delay_valid <= r_popped && r_rdata[31:0] != 32'd0;
                o_delay_us <= (r_popped && r_rdata[31:0] != 32'd0) ?
                    r_now - r_rdata[31:0] : 32'd0;
                o_packets_seen <= r_seen;
                o_packets_missing <= r_lost;
                o_overrun_count <= r_over;
                o_underrun_count <= r_under;
            end
        end
    end

    assign o_valid = r_ovalid;

endmodule

FILE: hdl/audio_jitter_buffer.sv
// Top level of the stereo audio jitter buffer: configuration registers and the
// front and back parts. Uses ajb_pkg, ajb_front and ajb_back.
// Frame and batch-start requests are handled in the back part's idle state; a header
// with a sequence gap moves on to the silence state to insert silent frames, and a read
// passes the read and emit states, emitting one copy per upsample ratio step. The back
// part handles one request at a time while a four-entry queue accepts input until full.
module audio_jitter_buffer
    import ajb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_seq_num,
    input  logic [15:0] i_frame_count,
    input  logic [15:0] i_left_in,
    input  logic [15:0] i_right_in,
    input  logic        i_end_of_packet,
    input  logic [31:0] i_time_us,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_left_out,
    output logic [15:0] o_right_out,
    output logic        o_last_copy,
    output logic        o_underrun_flag,
    output logic [1:0]  o_stream_mode,
    output logic [8:0]  o_fill_level,
    output logic [31:0] o_delay_us,
    output logic        o_delay_valid,
    output logic [31:0] o_packets_seen,
    output logic [31:0] o_packets_missing,
    output logic [31:0] o_overrun_count,
    output logic [31:0] o_underrun_count
);

    logic [3:0] r_ratio;
    logic [8:0] r_prebuf, r_target, r_max;
    logic       req_valid, req_pop;
    t_req       req;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= 4'd1;
            r_prebuf <= 9'd16;
            r_target <= 9'd24;
            r_max <= 9'd48;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RATIO: r_ratio <= i_cfg_data[3:0];
                CFG_PREBUF: r_prebuf <= i_cfg_data;
                CFG_TARGET: r_target <= i_cfg_data;
                CFG_MAX: r_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ajb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_opcode(i_opcode), .i_seq_num(i_seq_num), .i_frame_count(i_frame_count),
        .i_left_in(i_left_in), .i_right_in(i_right_in),
        .i_end_of_packet(i_end_of_packet), .i_time_us(i_time_us),
        .o_req_valid(req_valid), .o_req(req), .i_req_pop(req_pop)
    );

    ajb_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req_valid(req_valid), .i_req(req),
        .o_req_pop(req_pop), .i_ratio(r_ratio), .i_prebuf(r_prebuf),
        .i_target(r_target), .i_max(r_max), .o_valid(o_valid), .i_stall(i_stall),
        .o_left_out(o_left_out), .o_right_out(o_right_out), .o_last_copy(o_last_copy),
        .o_underrun_flag(o_underrun_flag), .o_stream_mode(o_stream_mode),
        .o_fill_level(o_fill_level), .o_delay_us(o_delay_us),
        .o_delay_valid(o_delay_valid), .o_packets_seen(o_packets_seen),
        .o_packets_missing(o_packets_missing), .o_overrun_count(o_overrun_count),
        .o_underrun_count(o_underrun_count)
    );

endmodule
